>>> rtl/core/trv_pkg.sv
// ----------------------------------------------------------------------------
// trv_pkg
// Shared constants, command types and the single-round update function of the
// Trivium keystream cipher.
// ----------------------------------------------------------------------------
package trv_pkg;

    localparam int STATE_BITS        = 288;
    localparam int WARMUP_PASSES_DEF = 4;
    localparam int BITS_PER_ITEM_DEF = 8;
    localparam int KEY_BITS          = 80;
    localparam int IV_BASE           = 93;
    localparam int ADDR_W            = 5;
    localparam int DATA_W            = 64;
    localparam int LOW_W             = 64;
    localparam int HIGH_W            = 16;
    localparam int BYTE_W            = 8;

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_IV_LOW   = 2'd2;
    localparam logic [1:0] REG_IV_HIGH  = 2'd3;

    typedef struct packed {
        logic load;
        logic step_data;
        logic warm_full;
        logic warm_part;
        logic post_init;
    } t_dp_cmd;

    typedef struct packed {
        logic                  z;
        logic [STATE_BITS-1:0] s;
    } t_round;

    function automatic t_round trv_round(input logic [STATE_BITS-1:0] s);
        logic   a;
        logic   b;
        logic   c;
        t_round r;
        a   = s[65] ^ s[92];
        b   = s[161] ^ s[176];
        c   = s[242] ^ s[287];
        r.z = a ^ b ^ c;
        a   = a ^ (s[90] & s[91]) ^ s[170];
        b   = b ^ (s[174] & s[175]) ^ s[263];
        c   = c ^ (s[285] & s[286]) ^ s[68];
        r.s = {s[286:177], b, s[175:93], a, s[91:0], c};
        return r;
    endfunction

endpackage

>>> rtl/core/trv_regs.sv
// ----------------------------------------------------------------------------
// trv_regs
// APB-style configuration registers holding the key and IV.
// ----------------------------------------------------------------------------
module trv_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trv_pkg::ADDR_W-1:0]  paddr,
    input  logic [trv_pkg::DATA_W-1:0]  pwdata,
    output logic [trv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [trv_pkg::KEY_BITS-1:0] o_key,
    output logic [trv_pkg::KEY_BITS-1:0] o_iv
);

    logic [trv_pkg::LOW_W-1:0]  r_key_low;
    logic [trv_pkg::HIGH_W-1:0] r_key_high;
    logic [trv_pkg::LOW_W-1:0]  r_iv_low;
    logic [trv_pkg::HIGH_W-1:0] r_iv_high;
    logic                       w_wr;
    logic [1:0]                 w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[trv_pkg::ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_low   <= '0;
            r_iv_high  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                trv_pkg::REG_KEY_LOW:  r_key_low  <= pwdata;
                trv_pkg::REG_KEY_HIGH: r_key_high <= pwdata[trv_pkg::HIGH_W-1:0];
                trv_pkg::REG_IV_LOW:   r_iv_low   <= pwdata;
                trv_pkg::REG_IV_HIGH:  r_iv_high  <= pwdata[trv_pkg::HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            trv_pkg::REG_KEY_LOW:  prdata = r_key_low;
            trv_pkg::REG_KEY_HIGH: prdata = {{(trv_pkg::DATA_W-trv_pkg::HIGH_W){1'b0}}, r_key_high};
            trv_pkg::REG_IV_LOW:   prdata = r_iv_low;
            trv_pkg::REG_IV_HIGH:  prdata = {{(trv_pkg::DATA_W-trv_pkg::HIGH_W){1'b0}}, r_iv_high};
            default:               prdata = '0;
        endcase
    end

    assign o_key = {r_key_high, r_key_low};
    assign o_iv  = {r_iv_high, r_iv_low};

endmodule

>>> rtl/core/trv_datapath.sv
// ----------------------------------------------------------------------------
// trv_datapath
// The 288-bit cipher state with an unrolled multi-round update, and the
// result payload register.
// ----------------------------------------------------------------------------
module trv_datapath #(
    parameter int WARMUP_PASSES = trv_pkg::WARMUP_PASSES_DEF,
    parameter int BITS_PER_ITEM = trv_pkg::BITS_PER_ITEM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  trv_pkg::t_dp_cmd             i_cmd,
    input  logic [trv_pkg::KEY_BITS-1:0] i_key,
    input  logic [trv_pkg::KEY_BITS-1:0] i_iv,
    input  logic [trv_pkg::BYTE_W-1:0]   i_data_byte,
    output logic [trv_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [trv_pkg::BYTE_W-1:0]   o_stream_byte,
    output logic                         o_init_done
);

    localparam int SB       = trv_pkg::STATE_BITS;
    localparam int WARM_REM = (WARMUP_PASSES * SB) % BITS_PER_ITEM;

    logic [SB-1:0]              r_state;
    logic [SB-1:0]              n_state;
    logic [SB-1:0]              w_stage [0:BITS_PER_ITEM];
    logic [BITS_PER_ITEM-1:0]   w_z;
    logic [trv_pkg::BYTE_W-1:0] w_ks;
    logic [SB-1:0]              w_load;
    logic [trv_pkg::BYTE_W-1:0] r_out_byte;
    logic [trv_pkg::BYTE_W-1:0] r_stream_byte;
    logic                       r_init_done;

    assign w_stage[0] = r_state;

    genvar k;
    generate
        for (k = 0; k < BITS_PER_ITEM; k++) begin : g_round
            trv_pkg::t_round w_r;
            assign w_r          = trv_pkg::trv_round(w_stage[k]);
            assign w_stage[k+1] = w_r.s;
            assign w_z[k]       = w_r.z;
        end
        for (k = 0; k < trv_pkg::BYTE_W; k++) begin : g_ks
            if (k < BITS_PER_ITEM) begin : g_bit
                assign w_ks[k] = w_z[BITS_PER_ITEM-1-k];
            end else begin : g_zero
                assign w_ks[k] = 1'b0;
            end
        end
    endgenerate

    assign w_load = {3'b111,
                     {(SB-3-trv_pkg::IV_BASE-trv_pkg::KEY_BITS){1'b0}},
                     i_iv,
                     {(trv_pkg::IV_BASE-trv_pkg::KEY_BITS){1'b0}},
                     i_key};

    always_comb begin
        n_state = r_state;
        if (i_cmd.load) begin
            n_state = w_load;
        end else if (i_cmd.step_data || i_cmd.warm_full) begin
            n_state = w_stage[BITS_PER_ITEM];
        end else if (i_cmd.warm_part) begin
            n_state = w_stage[WARM_REM];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_data) begin
            r_out_byte    <= i_data_byte ^ w_ks;
            r_stream_byte <= w_ks;
            r_init_done   <= 1'b0;
        end else if (i_cmd.post_init) begin
            r_out_byte    <= '0;
            r_stream_byte <= '0;
            r_init_done   <= 1'b1;
        end
    end

    assign o_out_byte    = r_out_byte;
    assign o_stream_byte = r_stream_byte;
    assign o_init_done   = r_init_done;

endmodule

>>> rtl/core/trv_ctrl.sv
// ----------------------------------------------------------------------------
// trv_ctrl
// Controller: handshakes, warm-up sequencing and the result valid flag.
// ----------------------------------------------------------------------------
module trv_ctrl #(
    parameter int WARMUP_PASSES = trv_pkg::WARMUP_PASSES_DEF,
    parameter int BITS_PER_ITEM = trv_pkg::BITS_PER_ITEM_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_command,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output trv_pkg::t_dp_cmd o_cmd
);

    localparam int WARM_ROUNDS = WARMUP_PASSES * trv_pkg::STATE_BITS;
    localparam int WARM_CYC    = (WARM_ROUNDS + BITS_PER_ITEM - 1) / BITS_PER_ITEM;
    localparam int WARM_REM    = WARM_ROUNDS % BITS_PER_ITEM;
    localparam int CNT_W       = $clog2(WARM_CYC + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WARM = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_out_free;
    logic             w_last;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_last     = (r_cnt == '0);
    assign o_valid    = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept && (i_command == trv_pkg::CMD_INIT);
        o_cmd.step_data = w_accept && (i_command == trv_pkg::CMD_DATA);
        o_cmd.warm_full = (r_state == S_WARM) && !(w_last && (WARM_REM != 0));
        o_cmd.warm_part = (r_state == S_WARM) && w_last && (WARM_REM != 0);
        o_cmd.post_init = (r_state == S_POST) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_WARM;
                    n_cnt   = CNT_W'(WARM_CYC - 1);
                end
            end
            S_WARM: begin
                if (w_last) begin
                    n_state = S_POST;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_POST: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.step_data || o_cmd.post_init) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.step_data, o_cmd.warm_full, o_cmd.warm_part,
                  o_cmd.post_init}))
        else $error("More than one datapath command in a cycle.");

    a_load_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_WARM) && (r_cnt == CNT_W'(WARM_CYC - 1)))
        else $error("Init transaction did not start the warm-up.");

    a_warm_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WARM) && w_last |=> (r_state == S_POST))
        else $error("Warm-up did not end after its last cycle.");

    a_post_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.post_init |=> o_valid && (r_state == S_IDLE))
        else $error("Init result was not presented.");

endmodule

>>> rtl/core/trivium_keystream_cipher.sv
// ----------------------------------------------------------------------------
// trivium_keystream_cipher
// Trivium stream cipher with an 80-bit key and IV over a 288-bit state.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_valid / o_stall  i_command, i_data_byte
//   output   out        o_valid / i_stall  o_out_byte, o_stream_byte, o_init_done
//   config   in         APB write / read   key_low, key_high, iv_low, iv_high
//
// BITS_PER_ITEM rounds are unrolled per cycle, and data transactions may follow
// each other in consecutive cycles while the output is not stalled. An init
// transaction loads the key and IV and runs WARMUP_PASSES * 288 warm-up rounds,
// paced by the warm-up counter in the controller, before its result is shown.
// Reset clears the state, the configuration registers and the handshake logic.
// A stalled result holds the output register and blocks new transactions.
// ----------------------------------------------------------------------------
module trivium_keystream_cipher #(
    parameter int WARMUP_PASSES = trv_pkg::WARMUP_PASSES_DEF,
    parameter int BITS_PER_ITEM = trv_pkg::BITS_PER_ITEM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic [trv_pkg::BYTE_W-1:0]  i_data_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [trv_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [trv_pkg::BYTE_W-1:0]  o_stream_byte,
    output logic                        o_init_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trv_pkg::ADDR_W-1:0]  paddr,
    input  logic [trv_pkg::DATA_W-1:0]  pwdata,
    output logic [trv_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    trv_pkg::t_dp_cmd             w_cmd;
    logic [trv_pkg::KEY_BITS-1:0] w_key;
    logic [trv_pkg::KEY_BITS-1:0] w_iv;

    trv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key),
        .o_iv    (w_iv)
    );

    trv_ctrl #(
        .WARMUP_PASSES (WARMUP_PASSES),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd     (w_cmd)
    );

    trv_datapath #(
        .WARMUP_PASSES (WARMUP_PASSES),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_key         (w_key),
        .i_iv          (w_iv),
        .i_data_byte   (i_data_byte),
        .o_out_byte    (o_out_byte),
        .o_stream_byte (o_stream_byte),
        .o_init_done   (o_init_done)
    );

endmodule

>>> tb/trivium_cipher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trivium_cipher_checker
// Watches the input, output and register ports of the Trivium keystream
// cipher. It keeps its own copy of the key, the IV and the 288-bit cipher
// state, predicts the result of every accepted input transaction and compares
// each accepted output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module trivium_cipher_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_command,
    input  logic [trv_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [trv_pkg::BYTE_W-1:0]  i_out_byte,
    input  logic [trv_pkg::BYTE_W-1:0]  i_stream_byte,
    input  logic                        i_init_done,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [trv_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [trv_pkg::DATA_W-1:0]  i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic [trv_pkg::BYTE_W-1:0] out_byte;
        logic [trv_pkg::BYTE_W-1:0] stream_byte;
        logic                       init_done;
    } t_cipher_result;

    logic [trv_pkg::STATE_BITS-1:0] cipher_st;
    logic [trv_pkg::LOW_W-1:0]      key_lo;
    logic [trv_pkg::HIGH_W-1:0]     key_hi;
    logic [trv_pkg::LOW_W-1:0]      iv_lo;
    logic [trv_pkg::HIGH_W-1:0]     iv_hi;
    t_cipher_result                 result_q[$];

    function automatic logic next_stream_bit();
        logic t1;
        logic t2;
        logic t3;
        logic z;
        t1 = cipher_st[65] ^ cipher_st[92];
        t2 = cipher_st[161] ^ cipher_st[176];
        t3 = cipher_st[242] ^ cipher_st[287];
        z  = t1 ^ t2 ^ t3;
        t1 = t1 ^ (cipher_st[90] & cipher_st[91]) ^ cipher_st[170];
        t2 = t2 ^ (cipher_st[174] & cipher_st[175]) ^ cipher_st[263];
        t3 = t3 ^ (cipher_st[285] & cipher_st[286]) ^ cipher_st[68];
        cipher_st[92:1]    = cipher_st[91:0];
        cipher_st[0]       = t3;
        cipher_st[176:94]  = cipher_st[175:93];
        cipher_st[93]      = t1;
        cipher_st[287:178] = cipher_st[286:177];
        cipher_st[177]     = t2;
        return z;
    endfunction

    function automatic void load_and_warm_up();
        int r;
        cipher_st          = '0;
        cipher_st[79:0]    = {key_hi, key_lo};
        cipher_st[172:93]  = {iv_hi, iv_lo};
        cipher_st[287:285] = 3'b111;
        for (r = 0; r < trv_pkg::WARMUP_PASSES_DEF * trv_pkg::STATE_BITS; r++) begin
            void'(next_stream_bit());
        end
    endfunction

    function automatic t_cipher_result predict_result(
            input logic cmd, input logic [trv_pkg::BYTE_W-1:0] data);
        t_cipher_result res;
        logic [63:0]    ks_word;
        int             i;
        if (cmd == trv_pkg::CMD_INIT) begin
            load_and_warm_up();
            res.out_byte    = '0;
            res.stream_byte = '0;
            res.init_done   = 1'b1;
        end else begin
            ks_word = '0;
            for (i = 0; i < trv_pkg::BITS_PER_ITEM_DEF; i++) begin
                ks_word = {ks_word[62:0], next_stream_bit()};
            end
            res.stream_byte = ks_word[trv_pkg::BYTE_W-1:0];
            res.out_byte    = data ^ ks_word[trv_pkg::BYTE_W-1:0];
            res.init_done   = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_cipher_result want;
        if (!i_rst_n) begin
            cipher_st = '0;
            key_lo    = '0;
            key_hi    = '0;
            iv_lo     = '0;
            iv_hi     = '0;
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[trv_pkg::ADDR_W-1:3])
                    trv_pkg::REG_KEY_LOW:  key_lo = i_pwdata[trv_pkg::LOW_W-1:0];
                    trv_pkg::REG_KEY_HIGH: key_hi = i_pwdata[trv_pkg::HIGH_W-1:0];
                    trv_pkg::REG_IV_LOW:   iv_lo  = i_pwdata[trv_pkg::LOW_W-1:0];
                    trv_pkg::REG_IV_HIGH:  iv_hi  = i_pwdata[trv_pkg::HIGH_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("[%0t] unexpected result: out=%h ks=%h done=%b",
                                 $realtime, i_out_byte, i_stream_byte, i_init_done);
                    end
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (want.out_byte !== i_out_byte || want.stream_byte !== i_stream_byte
                            || want.init_done !== i_init_done) begin
                        if (o_fail_count < 10) begin
                            $display("[%0t] mismatch: expected %h %h %b, got %h %h %b",
                                     $realtime, want.out_byte, want.stream_byte,
                                     want.init_done, i_out_byte, i_stream_byte,
                                     i_init_done);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_q.insert(result_q.size(), predict_result(i_command, i_data_byte));
            end
        end
        o_pending = result_q.size();
    end

endmodule

>>> tb/trivium_keystream_cipher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trivium_keystream_cipher_tb
// Drives the Trivium keystream cipher with directed and random transactions:
// keystream from the reset state, extreme and random keys and IVs, repeated
// initialization and long data runs, with bursty input and a varying output
// stall pattern. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module trivium_keystream_cipher_tb;

    localparam int ITEM_TARGET = 550;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_command;
    logic [trv_pkg::BYTE_W-1:0]   i_data_byte;
    logic                         o_valid;
    logic                         i_stall;
    logic [trv_pkg::BYTE_W-1:0]   o_out_byte;
    logic [trv_pkg::BYTE_W-1:0]   o_stream_byte;
    logic                         o_init_done;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [trv_pkg::ADDR_W-1:0]   paddr;
    logic [trv_pkg::DATA_W-1:0]   pwdata;
    logic [trv_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int fail_count;
    int pending;
    int items_sent;
    int burst_left;
    int stall_mode;
    int stall_left;
    int stall_tick;

    logic [1:0] reg_ids[4] = '{trv_pkg::REG_KEY_LOW, trv_pkg::REG_KEY_HIGH,
                               trv_pkg::REG_IV_LOW, trv_pkg::REG_IV_HIGH};

    trivium_keystream_cipher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_stream_byte (o_stream_byte),
        .o_init_done   (o_init_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    trivium_cipher_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_byte    (o_out_byte),
        .i_stream_byte (o_stream_byte),
        .i_init_done   (o_init_done),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // The output side stalls in one of four modes, picked at random for a run of random length.
    initial begin : out_stall
        i_stall    = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        stall_tick = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: i_stall = 1'b0;
                1: i_stall = ($urandom_range(0, 3) == 0);
                2: i_stall = ($urandom_range(0, 3) != 0);
                default: i_stall = (stall_tick % 8 < 3);
            endcase
            stall_tick++;
        end
    end

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_item(input logic cmd, input logic [trv_pkg::BYTE_W-1:0] data);
        int gap;
        i_valid     = 1'b1;
        i_command   = cmd;
        i_data_byte = data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid     = 1'b0;
                i_command   = 1'($urandom_range(0, 1));
                i_data_byte = 8'($urandom_range(0, 255));
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic send_data_run(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_item(trv_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic settle();
        if (i_valid) i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int  n_msg;
        int  m;
        int  k;
        int  len;
        logic first_phase;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = trv_pkg::CMD_DATA;
        i_data_byte = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        items_sent  = 0;
        burst_left  = 4;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Keystream from the all-zero reset state, then init with a zero key.
        send_item(trv_pkg::CMD_DATA, 8'h00);
        send_item(trv_pkg::CMD_DATA, 8'hFF);
        send_item(trv_pkg::CMD_DATA, 8'h5A);
        send_item(trv_pkg::CMD_INIT, 8'hFF);
        send_item(trv_pkg::CMD_DATA, 8'h00);
        send_item(trv_pkg::CMD_DATA, 8'hFF);
        settle();

        // All-ones key and IV, with upper bits set on the narrow registers.
        for (k = 0; k < 4; k++) write_reg(reg_ids[k], '1);
        send_item(trv_pkg::CMD_INIT, 8'h00);
        send_item(trv_pkg::CMD_DATA, 8'h80);
        send_item(trv_pkg::CMD_DATA, 8'h01);
        send_item(trv_pkg::CMD_DATA, 8'hFF);
        send_item(trv_pkg::CMD_DATA, 8'h00);
        send_item(trv_pkg::CMD_INIT, 8'hA5);
        send_item(trv_pkg::CMD_DATA, 8'h00);
        send_item(trv_pkg::CMD_DATA, 8'h00);
        settle();

        // Single bits at the ends of the key field and at the low/high boundary of the IV.
        write_reg(trv_pkg::REG_KEY_LOW, 64'h1);
        write_reg(trv_pkg::REG_KEY_HIGH, 64'h8000);
        write_reg(trv_pkg::REG_IV_LOW, 64'h8000_0000_0000_0000);
        write_reg(trv_pkg::REG_IV_HIGH, 64'h1);
        send_item(trv_pkg::CMD_INIT, 8'h00);
        send_item(trv_pkg::CMD_DATA, 8'h00);
        send_item(trv_pkg::CMD_DATA, 8'hFF);
        settle();

        // Zero key and IV written back after nonzero values.
        for (k = 0; k < 4; k++) write_reg(reg_ids[k], '0);
        send_item(trv_pkg::CMD_INIT, 8'h3C);
        send_item(trv_pkg::CMD_DATA, 8'hC3);
        settle();

        first_phase = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            if (first_phase || $urandom_range(0, 3) != 0) begin
                for (k = 0; k < 4; k++) begin
                    if (first_phase || $urandom_range(0, 2) != 0) begin
                        write_reg(reg_ids[k], pick_reg_value());
                    end
                end
            end
            first_phase = 1'b0;
            // Occasionally the keystream simply continues before a new init.
            if ($urandom_range(0, 5) == 0) send_data_run($urandom_range(1, 6));
            n_msg = $urandom_range(1, 3);
            for (m = 0; m < n_msg; m++) begin
                send_item(trv_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
                send_data_run(len);
            end
            settle();
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
